[hdl/glc_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// glc_pkg
// Shared constants, types and helpers of the glyph LRU tag cache.
// ============================================================================
package glc_pkg;

    localparam int SLOTS        = 256;
    localparam int DIRECT_FIRST = 32;
    localparam int DIRECT_LAST  = 126;

    localparam int DIRECT_COUNT = DIRECT_LAST - DIRECT_FIRST + 1;
    localparam int DIRECT_W     = (DIRECT_COUNT > 1) ? $clog2(DIRECT_COUNT) : 1;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int CNT_W        = SLOT_W + 1;

    localparam int CODE_W    = 21;
    localparam int STAMP_W   = 32;
    localparam int INDEX_W   = 8;
    localparam int OUTCOME_W = 3;
    localparam int ENTRY_W   = CODE_W + STAMP_W;

    localparam logic [CODE_W-1:0] DIRECT_FIRST_C = CODE_W'(DIRECT_FIRST);
    localparam logic [CODE_W-1:0] DIRECT_LAST_C  = CODE_W'(DIRECT_LAST);
    localparam logic [CODE_W-1:0] DEL_CODE       = CODE_W'(8'h7F);
    localparam logic [CODE_W-1:0] SUBST_CODE     = CODE_W'(8'h3F);

    localparam logic [OUTCOME_W-1:0] OUT_NO_FONT     = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_DIRECT_HIT  = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_DIRECT_FILL = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_ASSOC_HIT   = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_ASSOC_FREE  = 3'd4;
    localparam logic [OUTCOME_W-1:0] OUT_ASSOC_EVICT = 3'd5;

    typedef struct packed {
        logic [CODE_W-1:0]  tag;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [INDEX_W-1:0]   slot_index;
        logic [CODE_W-1:0]    mapped_code;
        logic [CODE_W-1:0]    evicted_code;
    } t_result;

    function automatic logic [CODE_W-1:0] map_code(input logic [CODE_W-1:0] cp);
        if (cp < DIRECT_FIRST_C || cp == DEL_CODE) begin
            return SUBST_CODE;
        end
        return cp;
    endfunction

    function automatic logic is_direct(input logic [CODE_W-1:0] cp);
        return (cp >= DIRECT_FIRST_C) && (cp <= DIRECT_LAST_C);
    endfunction

    function automatic logic [INDEX_W-1:0] slot_to_index(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+INDEX_W-1:0] w;
        w = {{INDEX_W{1'b0}}, s};
        return w[INDEX_W-1:0];
    endfunction

    function automatic logic [INDEX_W-1:0] direct_to_index(input logic [DIRECT_W-1:0] d);
        logic [DIRECT_W+INDEX_W-1:0] w;
        w = {{INDEX_W{1'b0}}, d};
        return w[INDEX_W-1:0];
    endfunction

endpackage

[hdl/glc_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// glc_if
// Handshake channels of the glyph LRU tag cache: lookup, result and config.
// ============================================================================
interface glc_in_if;
    logic                       valid;
    logic                       ready;
    logic [glc_pkg::CODE_W-1:0] code_point;

    modport source (output valid, output code_point, input ready);
    modport sink (input valid, input code_point, output ready);
endinterface

interface glc_out_if;
    logic                          valid;
    logic                          ready;
    logic [glc_pkg::OUTCOME_W-1:0] outcome;
    logic [glc_pkg::INDEX_W-1:0]   slot_index;
    logic [glc_pkg::CODE_W-1:0]    mapped_code;
    logic [glc_pkg::CODE_W-1:0]    evicted_code;

    modport source (output valid, output outcome, output slot_index,
                    output mapped_code, output evicted_code, input ready);
    modport sink (input valid, input outcome, input slot_index,
                  input mapped_code, input evicted_code, output ready);
endinterface

interface glc_cfg_if;
    logic valid;
    logic ready;
    logic font_loaded;

    modport source (output valid, output font_loaded, input ready);
    modport sink (input valid, input font_loaded, output ready);
endinterface

[hdl/glc_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// glc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module glc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/glyph_lru_cache.sv]
`timescale 1ns / 1ps
// ============================================================================
// glyph_lru_cache
// Glyph cache tag store: direct table for printable ASCII, fully associative
// timestamp-LRU store above DEL; control codes and DEL map to 0x3F.
// ============================================================================
// Usage:
//   i_cfg  - write font_loaded; always ready, takes effect at once. Write it
//            only while no lookup is in flight.
//   i_in   - one code point per word. Ready is high only while the block is
//            idle; one lookup is worked on at a time.
//   o_out  - one result word per lookup, held in an output register until
//            taken, so the next lookup is accepted while it waits.
// Sequence:
//   No font or a direct code point: the lookup goes from idle to the done
//   state, which loads the output register once it is free, then to idle.
//   Associative lookup: the tag/stamp RAM is read one entry per cycle over
//   all SLOTS entries, then the chosen entry is written back in the finish
//   state, before the done state.
// Reset: clears font_loaded, the use counter and all valid bits; no RAM
//   clearing pass is needed, the block is ready in the first cycle.
// Stall: while a result waits and a second one is finished, the block holds
//   the second and accepts nothing more.
// ============================================================================
module glyph_lru_cache (
    input logic       i_clk,
    input logic       i_rst_n,
    glc_in_if.sink    i_in,
    glc_out_if.source o_out,
    glc_cfg_if.sink   i_cfg
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [glc_pkg::SLOT_W-1:0] LAST_SLOT =
        glc_pkg::SLOT_W'(glc_pkg::SLOTS - 1);
    localparam logic [glc_pkg::CNT_W-1:0] SLOT_END =
        glc_pkg::CNT_W'(glc_pkg::SLOTS);

    logic [1:0] r_state;
    logic [1:0] n_state;

    logic                                r_font;
    logic [glc_pkg::STAMP_W-1:0]         r_use_count;
    logic [glc_pkg::CODE_W-1:0]          r_cp;
    logic [glc_pkg::DIRECT_COUNT-1:0]    r_direct_valid;
    logic [glc_pkg::SLOTS-1:0]           r_slot_valid;
    logic [glc_pkg::CNT_W-1:0]           r_cnt;
    logic                                r_chk;
    logic [glc_pkg::SLOT_W-1:0]          r_chk_idx;
    logic                                r_hit;
    logic [glc_pkg::SLOT_W-1:0]          r_hit_idx;
    logic                                r_have_free;
    logic [glc_pkg::SLOT_W-1:0]          r_free_idx;
    logic [glc_pkg::STAMP_W-1:0]         r_min_stamp;
    logic [glc_pkg::CODE_W-1:0]          r_min_tag;
    logic [glc_pkg::SLOT_W-1:0]          r_min_idx;
    glc_pkg::t_result                    r_res;
    glc_pkg::t_result                    r_out;
    logic                                r_out_valid;

    logic                                in_acc;
    logic                                out_load;
    logic                                rd_en;
    logic [glc_pkg::CODE_W-1:0]          acc_cp;
    logic [glc_pkg::CODE_W-1:0]          acc_off;
    logic [glc_pkg::DIRECT_W-1:0]        acc_d;
    logic [glc_pkg::ENTRY_W-1:0]         rd_data;
    glc_pkg::t_entry                     rd_entry;
    logic                                chk_v;
    logic [glc_pkg::CODE_W-1:0]          chk_tag;
    logic [glc_pkg::STAMP_W-1:0]         chk_stamp;
    logic                                wr_en;
    logic [glc_pkg::SLOT_W-1:0]          wr_addr;
    glc_pkg::t_entry                     wr_entry;
    glc_pkg::t_result                    fin_res;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
    assign rd_en       = (r_state == S_SCAN) && (r_cnt < SLOT_END);

    assign acc_cp  = glc_pkg::map_code(i_in.code_point);
    assign acc_off = acc_cp - glc_pkg::DIRECT_FIRST_C;
    assign acc_d   = acc_off[glc_pkg::DIRECT_W-1:0];

    glc_ram #(
        .WIDTH (glc_pkg::ENTRY_W),
        .DEPTH (glc_pkg::SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_addr (r_cnt[glc_pkg::SLOT_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Invalid entries read as zero tag and stamp.
    always_comb begin
        rd_entry  = rd_data;
        chk_v     = r_slot_valid[r_chk_idx];
        chk_tag   = chk_v ? rd_entry.tag : '0;
        chk_stamp = chk_v ? rd_entry.stamp : '0;
    end

    always_comb begin
        wr_en                 = (r_state == S_FIN);
        wr_entry.tag          = r_cp;
        wr_entry.stamp        = r_use_count;
        fin_res.mapped_code   = r_cp;
        fin_res.evicted_code  = '0;
        priority if (r_hit) begin
            wr_addr         = r_hit_idx;
            fin_res.outcome = glc_pkg::OUT_ASSOC_HIT;
        end else if (r_have_free) begin
            wr_addr         = r_free_idx;
            fin_res.outcome = glc_pkg::OUT_ASSOC_FREE;
        end else begin
            wr_addr              = r_min_idx;
            fin_res.outcome      = glc_pkg::OUT_ASSOC_EVICT;
            fin_res.evicted_code = r_min_tag;
        end
        fin_res.slot_index = glc_pkg::slot_to_index(wr_addr);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (r_font && !glc_pkg::is_direct(acc_cp)) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (r_chk && r_chk_idx == LAST_SLOT) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_font         <= 1'b0;
            r_use_count    <= '0;
            r_direct_valid <= '0;
            r_slot_valid   <= '0;
            r_chk          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk   <= rd_en;
            if (i_cfg.valid && i_cfg.ready) begin
                r_font <= i_cfg.font_loaded;
            end
            if (in_acc && r_font) begin
                if (glc_pkg::is_direct(acc_cp)) begin
                    r_direct_valid[acc_d] <= 1'b1;
                end else begin
                    r_use_count <= r_use_count + 1'b1;
                end
            end
            if (r_state == S_FIN && !r_hit && r_have_free) begin
                r_slot_valid[r_free_idx] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cp        <= acc_cp;
            r_cnt       <= '0;
            r_hit       <= 1'b0;
            r_have_free <= 1'b0;
            if (!r_font) begin
                r_res <= '0;
            end else begin
                r_res.mapped_code  <= acc_cp;
                r_res.evicted_code <= '0;
                r_res.slot_index   <= glc_pkg::direct_to_index(acc_d);
                r_res.outcome      <= r_direct_valid[acc_d] ? glc_pkg::OUT_DIRECT_HIT
                                                            : glc_pkg::OUT_DIRECT_FILL;
            end
        end
        if (rd_en) begin
            r_cnt <= r_cnt + 1'b1;
        end
        r_chk_idx <= r_cnt[glc_pkg::SLOT_W-1:0];
        if (r_state == S_SCAN && r_chk) begin
            if (chk_v && chk_tag == r_cp && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_chk_idx;
            end
            if (!chk_v && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free_idx  <= r_chk_idx;
            end
            if (r_chk_idx == '0 || chk_stamp < r_min_stamp) begin
                r_min_stamp <= chk_stamp;
                r_min_tag   <= chk_tag;
                r_min_idx   <= r_chk_idx;
            end
        end
        if (r_state == S_FIN) begin
            r_res <= fin_res;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.outcome      = r_out.outcome;
    assign o_out.slot_index   = r_out.slot_index;
    assign o_out.mapped_code  = r_out.mapped_code;
    assign o_out.evicted_code = r_out.evicted_code;

endmodule

[hdl/glc_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// glc_checker
// Port-level checks of the glyph LRU tag cache, bound to the top level.
// ============================================================================
module glc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [glc_pkg::OUTCOME_W-1:0] i_outcome,
    input logic [glc_pkg::INDEX_W-1:0]   i_slot_index,
    input logic [glc_pkg::CODE_W-1:0]    i_mapped_code,
    input logic [glc_pkg::CODE_W-1:0]    i_evicted_code
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_outcome) && $stable(i_slot_index)
            && $stable(i_mapped_code) && $stable(i_evicted_code))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("lookup accepted while previous one in flight");

    a_outcome_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_outcome <= glc_pkg::OUT_ASSOC_EVICT)
        else $error("outcome code out of range");

    a_evict_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_outcome != glc_pkg::OUT_ASSOC_EVICT |-> i_evicted_code == '0)
        else $error("evicted code set without eviction");

endmodule

bind glyph_lru_cache glc_checker u_glc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_outcome      (o_out.outcome),
    .i_slot_index   (o_out.slot_index),
    .i_mapped_code  (o_out.mapped_code),
    .i_evicted_code (o_out.evicted_code)
);
